### hw/rtl/ycbcr_chroma_key_spill_core_macros.svh
// ----------------------------------------------------------------------------
// ycbcr chroma key assertion macros
// shared property wrappers for the keyer block
// ----------------------------------------------------------------------------
`ifndef YCBCR_CHROMA_KEY_SPILL_CORE_MACROS_SVH
`define YCBCR_CHROMA_KEY_SPILL_CORE_MACROS_SVH

// checked on clk_i, off while in reset
`define YCKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on clk_i, also during reset
`define YCKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/ycks_pkg.sv
// ----------------------------------------------------------------------------
// ycks_pkg
// types and constants for the ycbcr chroma keyer
// ----------------------------------------------------------------------------
package ycks_pkg;

  localparam int SQ_STEPS  = 25;
  localparam int RAD_W     = 2 * SQ_STEPS;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DIV_STEPS = 17;
  localparam int DIFF_W    = 18;
  localparam int MASK_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int CB_R = 11056;
  localparam int CB_G = 21712;
  localparam int CB_B = 32768;
  localparam int CR_R = 32768;
  localparam int CR_G = 27440;
  localparam int CR_B = 5328;

  localparam logic [26:0] RECIP_255 = 27'd67372037;
  localparam int          RECIP_SH  = 34;
  localparam int          SMOOTH_K  = 196608;
  localparam logic [MASK_W-1:0] MASK_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_RED   = 3'd0,
    REG_KEY_GREEN = 3'd1,
    REG_KEY_BLUE  = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_SOFTNESS  = 3'd4,
    REG_SPILL     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       match;
  } pix_t;

endpackage

### hw/rtl/ycks_if.sv
// ----------------------------------------------------------------------------
// ycks channel interfaces
// pixel in, pixel out and register write channels
// ----------------------------------------------------------------------------
interface ycks_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface ycks_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface ycks_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ycks_sqrt.sv
// ----------------------------------------------------------------------------
// ycks_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module ycks_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ycks_pkg::RAD_W-1:0]  rad_i,
  output logic [ycks_pkg::ROOT_W-1:0] root_o
);
  import ycks_pkg::*;

  logic [RAD_W-1:0]  rad_q  [SQ_STEPS];
  logic [REM_W-1:0]  rem_q  [SQ_STEPS];
  logic [ROOT_W-1:0] root_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [RAD_W-1:0]  rad_s;
    logic [REM_W-1:0]  rem_s;
    logic [ROOT_W-1:0] root_s;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_s  = rad_i;
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
    end

    assign rem_sh = {rem_s[REM_W-3:0], rad_s[RAD_W-1:RAD_W-2]};
    assign trial  = {root_s, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_s[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_s[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_s[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQ_STEPS-1];

endmodule

### hw/rtl/ycks_div.sv
// ----------------------------------------------------------------------------
// ycks_div
// pipelined restoring divider for the key mask, saturated to one
// ----------------------------------------------------------------------------
module ycks_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ycks_pkg::DIFF_W-1:0] diff_i,
  input  logic                        sat_i,
  input  logic [ycks_pkg::MASK_W-1:0] den_i,
  output logic [ycks_pkg::MASK_W-1:0] mask_o
);
  import ycks_pkg::*;

  logic [MASK_W-1:0] rem_q [DIV_STEPS];
  logic [MASK_W-1:0] quo_q [DIV_STEPS];
  logic              sat_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [MASK_W-1:0] rem_s;
    logic [MASK_W-1:0] quo_s;
    logic              sat_s;
    logic              nbit;
    logic [MASK_W:0]   rem_sh;

    if (k == 0) begin : g_first
      assign rem_s = diff_i[DIFF_W-1:1];
      assign quo_s = '0;
      assign sat_s = sat_i;
      assign nbit  = diff_i[0];
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign quo_s = quo_q[k-1];
      assign sat_s = sat_q[k-1];
      assign nbit  = 1'b0;
    end

    assign rem_sh = {rem_s, nbit};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[k] <= sat_s;
        if (rem_sh >= {1'b0, den_i}) begin
          rem_q[k] <= MASK_W'(rem_sh - {1'b0, den_i});
          quo_q[k] <= {quo_s[MASK_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem_sh[MASK_W-1:0];
          quo_q[k] <= {quo_s[MASK_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (sat_q[DIV_STEPS-1] || quo_q[DIV_STEPS-1] > MASK_ONE) begin
      mask_o = MASK_ONE;
    end else begin
      mask_o = quo_q[DIV_STEPS-1];
    end
  end

endmodule

### hw/rtl/ycbcr_chroma_key_spill_core.sv
// ----------------------------------------------------------------------------
// ycbcr_chroma_key_spill_core
// chroma keyer with smoothstep alpha mask and green spill suppression
// ----------------------------------------------------------------------------
// throughput: one word per cycle; the square root (25 stages) and the mask
// divider (17 stages) are fully pipelined, the whole pipe halts on output stall
// reset: clears valid bits and loads the key, threshold, softness and spill
// registers with their defaults
module ycbcr_chroma_key_spill_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  ycks_pix_in_if.sink    pix_i,
  ycks_pix_out_if.source pix_o,
  ycks_cfg_if.sink       cfg_i
);
  import ycks_pkg::*;

  `include "ycbcr_chroma_key_spill_core_macros.svh"

  localparam int NSTG     = 4 + SQ_STEPS + 2 + DIV_STEPS + 4;
  localparam int ST_ROOT  = 4 + SQ_STEPS;
  localparam int ST_MASK  = ST_ROOT + 2 + DIV_STEPS + 1;

  logic [7:0]  key_red_q, key_green_q, key_blue_q;
  logic [15:0] thr_q, soft_q, spill_q;

  logic        en;
  logic        in_acc, out_acc;
  logic [NSTG:1] vld_q;
  pix_t        pass_q [NSTG-1:1];

  logic signed [8:0]  dr_q, dg_q, db_q;
  logic signed [10:0] e_q;
  logic signed [25:0] cb_q, cr_q;
  logic [7:0]         green_d;
  logic [26:0]        num;
  logic [24:0]        cb_mag, cr_mag;
  logic [47:0]        cb2_q, cr2_q;
  logic [RAD_W-1:0]   rad_q;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W:0]    root_rnd;
  logic [52:0]        dist_prod;
  logic [DIFF_W-1:0]  dist_q;
  logic [DIFF_W-1:0]  diff_d, diff_q;
  logic               sat_q;
  logic [MASK_W-1:0]  den;
  logic [MASK_W-1:0]  mask, m_q;
  logic [31:0]        mm_q;
  logic [17:0]        fac_q;
  logic               full_q;
  logic [49:0]        sm_prod;
  logic [MASK_W-1:0]  s_q;
  logic [24:0]        a_prod;
  logic [7:0]         out_red_q, out_green_q, out_blue_q, out_alpha_q;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_red_q   <= 8'd0;
      key_green_q <= 8'd255;
      key_blue_q  <= 8'd0;
      thr_q       <= 16'd6554;
      soft_q      <= 16'd6554;
      spill_q     <= 16'd32768;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_KEY_RED:   key_red_q   <= cfg_i.data[7:0];
        REG_KEY_GREEN: key_green_q <= cfg_i.data[7:0];
        REG_KEY_BLUE:  key_blue_q  <= cfg_i.data[7:0];
        REG_THRESHOLD: thr_q       <= cfg_i.data;
        REG_SOFTNESS:  soft_q      <= cfg_i.data;
        REG_SPILL:     spill_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign en          = !vld_q[NSTG] || pix_o.ready;
  assign pix_i.ready = en;
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign out_acc     = pix_o.valid && pix_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-1:1], pix_i.valid};
    end
  end

  // stage 1: capture, key match, channel differences
  always_ff @(posedge clk_i) begin
    if (en) begin
      pass_q[1] <= '{red: pix_i.in_red, green: pix_i.in_green, blue: pix_i.in_blue,
                     alpha: pix_i.in_alpha,
                     match: (pix_i.in_red == key_red_q) && (pix_i.in_green == key_green_q)
                            && (pix_i.in_blue == key_blue_q)};
      dr_q <= 9'(int'(pix_i.in_red) - int'(key_red_q));
      dg_q <= 9'(int'(pix_i.in_green) - int'(key_green_q));
      db_q <= 9'(int'(pix_i.in_blue) - int'(key_blue_q));
      e_q  <= 11'(2 * int'(pix_i.in_green) - int'(pix_i.in_red) - int'(pix_i.in_blue));
    end
  end

  // stage 2: chroma differences and spill
  assign num = 27'(int'(pass_q[1].green) * 131072 - int'(e_q) * int'(spill_q));

  always_comb begin
    if (e_q > 11'sd0) begin
      green_d = 8'((num + 27'd65536) >> 17);
    end else begin
      green_d = pass_q[1].green;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cb_q <= 26'(CB_B * int'(db_q) - CB_R * int'(dr_q) - CB_G * int'(dg_q));
      cr_q <= 26'(CR_R * int'(dr_q) - CR_G * int'(dg_q) - CR_B * int'(db_q));
      pass_q[2] <= '{red: pass_q[1].red, green: green_d, blue: pass_q[1].blue,
                     alpha: pass_q[1].alpha, match: pass_q[1].match};
    end
  end

  // stage 3 and 4: squared distance
  assign cb_mag = cb_q[25] ? 25'(-cb_q) : cb_q[24:0];
  assign cr_mag = cr_q[25] ? 25'(-cr_q) : cr_q[24:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cb2_q <= 48'(cb_mag * cb_mag);
      cr2_q <= 48'(cr_mag * cr_mag);
      rad_q <= RAD_W'(cb2_q) + RAD_W'(cr2_q);
    end
  end

  ycks_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // distance scaled to full range, rounded divide by 255
  assign root_rnd  = {1'b0, root} + (ROOT_W+1)'(127);
  assign dist_prod = root_rnd * RECIP_255;
  assign diff_d    = (dist_q > DIFF_W'(thr_q)) ? dist_q - DIFF_W'(thr_q) : '0;
  assign den       = MASK_W'(soft_q) + MASK_W'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= DIFF_W'(dist_prod >> RECIP_SH);
      diff_q <= diff_d;
      sat_q  <= {1'b0, diff_d} >= {1'b0, den, 1'b0};
    end
  end

  ycks_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .diff_i (diff_q),
    .sat_i  (sat_q),
    .den_i  (den),
    .mask_o (mask)
  );

  // smoothstep
  assign sm_prod = mm_q * fac_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= mask;
      full_q <= m_q[MASK_W-1];
      mm_q   <= m_q[MASK_W-2:0] * m_q[MASK_W-2:0];
      fac_q  <= 18'(SMOOTH_K - 2 * int'(m_q));
      s_q    <= full_q ? MASK_ONE : MASK_W'((sm_prod + 50'h0_8000_0000) >> 32);
    end
  end

  for (genvar k = 3; k < NSTG; k++) begin : g_pass
    always_ff @(posedge clk_i) begin
      if (en) begin
        pass_q[k] <= pass_q[k-1];
      end
    end
  end

  // output word
  assign a_prod = s_q * pass_q[NSTG-1].alpha;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pass_q[NSTG-1].match) begin
        out_red_q   <= '0;
        out_green_q <= '0;
        out_blue_q  <= '0;
        out_alpha_q <= '0;
      end else begin
        out_red_q   <= pass_q[NSTG-1].red;
        out_green_q <= pass_q[NSTG-1].green;
        out_blue_q  <= pass_q[NSTG-1].blue;
        out_alpha_q <= 8'((a_prod + 25'd32768) >> 16);
      end
    end
  end

  assign pix_o.valid     = vld_q[NSTG];
  assign pix_o.out_red   = out_red_q;
  assign pix_o.out_green = out_green_q;
  assign pix_o.out_blue  = out_blue_q;
  assign pix_o.out_alpha = out_alpha_q;

  `YCKS_ASSERT(a_occupancy, rst_ni |=> $countones(vld_q) == $past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)), "pipeline word count drifted")
  `YCKS_ASSERT(a_mask_range, vld_q[ST_MASK] |-> m_q <= MASK_ONE, "key mask above one")
  `YCKS_ASSERT(a_smooth_range, vld_q[NSTG-1] |-> s_q <= MASK_ONE, "smoothstep above one")
  `YCKS_ASSERT_ALWAYS(a_ready_follows_out, (!pix_o.valid) |-> pix_i.ready, "input stalled on empty output")

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// keyer testbench: a directed table and random pixels under several key
// settings and idle patterns, every output word checked against a typed value or an
// in-bench fixed point model of the key mask and the spill suppression
// ----------------------------------------------------------------------------
module tb;
  import ycks_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct {
    rgba_t pix;
    bit    typed;
    rgba_t want;
  } table_row_t;

  typedef enum int {NO_IDLE, SRC_IDLE, SNK_IDLE, BOTH_IDLE} idle_e;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ycks_pix_in_if  pix_in ();
  ycks_pix_out_if pix_out ();
  ycks_cfg_if     cfg ();

  ycbcr_chroma_key_spill_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_in.sink),
    .pix_o  (pix_out.source),
    .cfg_i  (cfg.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // key settings as the block should hold them
  logic [7:0]  key_r, key_g, key_b;
  logic [15:0] thresh, softness, spill;

  rgba_t keyed_q[$];
  int    err_cnt = 0;
  idle_e idle_mode = NO_IDLE;
  logic  hold_on = 1'b0;
  bit    hold_go = 1'b0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic rgba_t key_pixel(rgba_t p);
    rgba_t o;
    longint dr, dg, db, cb, cr;
    longint unsigned sq, dist_val, m, q, s, e, num, grn;
    if (p.red == key_r && p.green == key_g && p.blue == key_b) return '0;
    dr = longint'(p.red) - longint'(key_r);
    dg = longint'(p.green) - longint'(key_g);
    db = longint'(p.blue) - longint'(key_b);
    cb = -11056 * dr - 21712 * dg + 32768 * db;
    cr = 32768 * dr - 27440 * dg - 5328 * db;
    sq = longint'(cb * cb) + longint'(cr * cr);
    dist_val = (isqrt(sq) + 127) / 255;
    m = 0;
    if (dist_val > thresh) begin
      q = ((dist_val - thresh) << 16) / (longint'(softness) + 1);
      m = (q > 65536) ? 65536 : q;
    end
    s = (m * m * (196608 - 2 * m) + (64'd1 << 31)) >> 32;
    grn = p.green;
    if (2 * int'(p.green) > int'(p.red) + int'(p.blue)) begin
      e = 2 * p.green - p.red - p.blue;
      num = longint'(p.green) * 131072 - e * spill;
      grn = (num + 65536) >> 17;
    end
    o.red   = p.red;
    o.green = grn[7:0];
    o.blue  = p.blue;
    o.alpha = 8'((s * p.alpha + 32768) >> 16);
    return o;
  endfunction

  function automatic bit idle_draw(bit src_side);
    int pct;
    pct = 0;
    case (idle_mode)
      SRC_IDLE:  pct = src_side ? 59 : 0;
      SNK_IDLE:  pct = src_side ? 0 : 59;
      BOTH_IDLE: pct = 37;
      default:   pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  task automatic report(string what, logic [7:0] want, logic [7:0] got);
    $display("mismatch %s: expected %0d got %0d", what, want, got);
    err_cnt++;
  endtask

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial pix_out.ready = 1'b0;

  always @(posedge clk_i) begin
    rgba_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (keyed_q.size() == 0) begin
        report("unexpected word red", 8'd0, pix_out.out_red);
      end else begin
        want = keyed_q.pop_front();
        if (pix_out.out_red !== want.red) report("red", want.red, pix_out.out_red);
        if (pix_out.out_green !== want.green) report("green", want.green, pix_out.out_green);
        if (pix_out.out_blue !== want.blue) report("blue", want.blue, pix_out.out_blue);
        if (pix_out.out_alpha !== want.alpha) report("alpha", want.alpha, pix_out.out_alpha);
      end
    end
    pix_out.ready <= hold_on ? 1'b0 : !idle_draw(1'b0);
  end

  task automatic send_pixel(rgba_t p, bit typed, rgba_t want);
    while (idle_draw(1'b1)) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.in_red   <= p.red;
    pix_in.in_green <= p.green;
    pix_in.in_blue  <= p.blue;
    pix_in.in_alpha <= p.alpha;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    keyed_q.push_back(typed ? want : key_pixel(p));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    case (idx)
      REG_KEY_RED:   key_r = val[7:0];
      REG_KEY_GREEN: key_g = val[7:0];
      REG_KEY_BLUE:  key_b = val[7:0];
      REG_THRESHOLD: thresh = val;
      REG_SOFTNESS:  softness = val;
      REG_SPILL:     spill = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    while (keyed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_key(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                         logic [15:0] th, logic [15:0] sf, logic [15:0] sp);
    write_reg(REG_KEY_RED, {8'($urandom), r});
    write_reg(REG_KEY_GREEN, 16'(g));
    write_reg(REG_KEY_BLUE, 16'(b));
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_SOFTNESS, sf);
    write_reg(REG_SPILL, sp);
  endtask

  function automatic logic [7:0] near(logic [7:0] c, int span);
    int v;
    v = int'(c) + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic random_pixels(int count);
    rgba_t p;
    int sel;
    repeat (count) begin
      sel = $urandom_range(9);
      p = rgba_t'($urandom);
      if (sel == 0) begin
        p.red = key_r; p.green = key_g; p.blue = key_b;
      end else if (sel < 6) begin
        p.red = near(key_r, 1 << $urandom_range(6));
        p.green = near(key_g, 1 << $urandom_range(6));
        p.blue = near(key_b, 1 << $urandom_range(6));
      end
      send_pixel(p, 1'b0, '0);
    end
  endtask

  table_row_t rows[$];

  initial begin
    pix_in.valid = 1'b0;
    pix_in.in_red = '0;
    pix_in.in_green = '0;
    pix_in.in_blue = '0;
    pix_in.in_alpha = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    key_r = 8'd0; key_g = 8'd255; key_b = 8'd0;
    thresh = 16'd6554; softness = 16'd6554; spill = 16'd32768;

    // exact key match and far-off black are typed, the rest predicted
    rows = '{
      '{'{8'd0, 8'd255, 8'd0, 8'd255}, 1'b1, '0},
      '{'{8'd0, 8'd255, 8'd0, 8'd0},   1'b1, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd255},   1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}},
      '{'{8'd0, 8'd0, 8'd0, 8'd0},     1'b1, '0},
      '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
      '{'{8'd255, 8'd0, 8'd255, 8'd128},   1'b0, '0},
      '{'{8'd0, 8'd255, 8'd1, 8'd255},     1'b0, '0},
      '{'{8'd0, 8'd254, 8'd0, 8'd200},     1'b0, '0},
      '{'{8'd1, 8'd255, 8'd0, 8'd255},     1'b0, '0},
      '{'{8'd20, 8'd230, 8'd15, 8'd255},   1'b0, '0},
      '{'{8'd128, 8'd200, 8'd64, 8'd77},   1'b0, '0},
      '{'{8'd255, 8'd255, 8'd0, 8'd1},     1'b0, '0},
      '{'{8'd0, 8'd128, 8'd0, 8'd255},     1'b0, '0},
      '{'{8'd0, 8'd0, 8'd255, 8'd255},     1'b0, '0},
      '{'{8'd255, 8'd0, 8'd0, 8'd255},     1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pixel(rows[i].pix, rows[i].typed, rows[i].want);
    drain();

    // hard step, full spill; spare indexes must be ignored
    set_key(8'd0, 8'd255, 8'd0, 16'd0, 16'd0, 16'd65535);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    idle_mode = NO_IDLE;
    foreach (rows[i]) send_pixel(rows[i].pix, 1'b0, '0);
    hold_go = 1'b1;
    random_pixels(250);
    drain();

    set_key(8'd255, 8'd255, 8'd255, 16'd65535, 16'd65535, 16'd0);
    idle_mode = SRC_IDLE;
    random_pixels(200);
    drain();

    set_key(8'($urandom), 8'($urandom), 8'($urandom),
            16'($urandom_range(12000)), 16'($urandom), 16'($urandom));
    idle_mode = SNK_IDLE;
    random_pixels(250);
    drain();

    set_key(8'($urandom), 8'($urandom), 8'($urandom),
            16'($urandom), 16'($urandom_range(3000)), 16'($urandom));
    idle_mode = BOTH_IDLE;
    random_pixels(250);
    drain();

    if (err_cnt == 0) begin
      $display("[ycbcr_chroma_key_spill_core] OK");
    end else begin
      $display("[ycbcr_chroma_key_spill_core] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[ycbcr_chroma_key_spill_core] ERROR");
    $finish;
  end

endmodule
